@@ sv/oqkr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oqkr_pkg
// Shared codes and types for the ordered queue with keyed removal.
// ---------------------------------------------------------------------------
package oqkr_pkg;

    // request operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // operation broadcast along the cell row
    typedef struct packed {
        logic do_append;
        logic do_remove;
        logic do_pop;
    } t_cell_ctl;

endpackage

@@ sv/oqkr_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oqkr_cell
// One queue slot: holds a key and handle, compares against the search key,
// takes the tail write on append and the right neighbour's word on removal.
// ---------------------------------------------------------------------------
module oqkr_cell #(
    parameter int IDX          = 0,
    parameter int DEPTH        = 16,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 32,
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  oqkr_pkg::t_cell_ctl     i_ctl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [KEY_WIDTH-1:0]    i_key,
    input  logic [HANDLE_WIDTH-1:0] i_handle,
    input  logic [KEY_WIDTH-1:0]    i_next_key,
    input  logic [HANDLE_WIDTH-1:0] i_next_handle,
    input  logic                    i_hit_before,
    output logic                    o_hit_through,
    output logic                    o_take,
    output logic [KEY_WIDTH-1:0]    o_key,
    output logic [HANDLE_WIDTH-1:0] o_handle,
    output logic [KEY_WIDTH-1:0]    o_take_key,
    output logic [HANDLE_WIDTH-1:0] o_take_handle
);

    logic [KEY_WIDTH-1:0]    r_key;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [KEY_WIDTH-1:0]    n_key;
    logic [HANDLE_WIDTH-1:0] n_handle;
    logic                    w_occupied;
    logic                    w_at_tail;
    logic                    w_match;

    // slot state relative to the fill level
    assign w_occupied = CNT_W'(IDX) < i_count;
    assign w_at_tail  = CNT_W'(IDX) == i_count;

    // pop hits the head slot when it is occupied; removal hits on key equality
    assign w_match = w_occupied &&
                     ((i_ctl.do_remove && (r_key == i_key)) ||
                      (i_ctl.do_pop && (IDX == 0)));

    // first hit along the row is the one removed
    assign o_hit_through = i_hit_before | w_match;
    assign o_take        = w_match & ~i_hit_before;

    assign o_key         = r_key;
    assign o_handle      = r_handle;
    assign o_take_key    = o_take ? r_key : '0;
    assign o_take_handle = o_take ? r_handle : '0;

    // next slot contents: tail write or shift up behind the hole
    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.do_append && w_at_tail) begin
            n_key    = i_key;
            n_handle = i_handle;
        end else if ((i_ctl.do_remove || i_ctl.do_pop) && o_hit_through) begin
            n_key    = i_next_key;
            n_handle = i_next_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

endmodule

@@ sv/ordered_queue_keyed_remove.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_queue_keyed_remove
// Ordered queue with append, pop and remove-oldest-by-key over a cell row.
// Every slot compares and shifts in parallel; the result word is registered.
// Throughput: one word per cycle while result words are being taken.
// Output register frees in the cycle its word is taken.
// Reset (synchronous, active low) empties the queue and the output register.
// ---------------------------------------------------------------------------
module ordered_queue_keyed_remove #(
    parameter int DEPTH        = 16,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 32,
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [KEY_WIDTH-1:0]    i_msg_key,
    input  logic [HANDLE_WIDTH-1:0] i_msg_handle,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [KEY_WIDTH-1:0]    o_out_key,
    output logic [HANDLE_WIDTH-1:0] o_out_handle,
    output logic [CNT_W-1:0]        o_count
);

    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [KEY_WIDTH-1:0]    r_out_key;
    logic [HANDLE_WIDTH-1:0] r_out_handle;
    logic [CNT_W-1:0]        r_out_count;
    logic [CNT_W-1:0]        r_count;
    logic [1:0]              n_status;
    logic [KEY_WIDTH-1:0]    n_out_key;
    logic [HANDLE_WIDTH-1:0] n_out_handle;
    logic [CNT_W-1:0]        n_count;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_hit;
    oqkr_pkg::t_cell_ctl     w_ctl;

    logic [DEPTH:0]          w_hit_chain;
    logic [DEPTH-1:0]        w_take;
    logic [KEY_WIDTH-1:0]    w_key    [DEPTH];
    logic [HANDLE_WIDTH-1:0] w_handle [DEPTH];
    logic [KEY_WIDTH-1:0]    w_tkey   [DEPTH];
    logic [HANDLE_WIDTH-1:0] w_thandle[DEPTH];
    logic [KEY_WIDTH-1:0]    w_sel_key;
    logic [HANDLE_WIDTH-1:0] w_sel_handle;

    // handshake: output register parts the two sides
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_full     = r_count == CNT_W'(DEPTH);

    // decode request into the row broadcast
    always_comb begin
        w_ctl = '0;
        if (w_accept) begin
            case (i_req_type)
                oqkr_pkg::OP_APPEND: w_ctl.do_append = ~w_full;
                oqkr_pkg::OP_REMOVE: w_ctl.do_remove = 1'b1;
                oqkr_pkg::OP_POP:    w_ctl.do_pop    = 1'b1;
                default:             w_ctl = '0;
            endcase
        end
    end

    // cell row
    assign w_hit_chain[0] = 1'b0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_WIDTH-1:0]    w_nk;
        logic [HANDLE_WIDTH-1:0] w_nh;
        if (g == DEPTH - 1) begin : g_last
            assign w_nk = '0;
            assign w_nh = '0;
        end else begin : g_mid
            assign w_nk = w_key[g+1];
            assign w_nh = w_handle[g+1];
        end
        oqkr_cell #(
            .IDX          (g),
            .DEPTH        (DEPTH),
            .KEY_WIDTH    (KEY_WIDTH),
            .HANDLE_WIDTH (HANDLE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_key         (i_msg_key),
            .i_handle      (i_msg_handle),
            .i_next_key    (w_nk),
            .i_next_handle (w_nh),
            .i_hit_before  (w_hit_chain[g]),
            .o_hit_through (w_hit_chain[g+1]),
            .o_take        (w_take[g]),
            .o_key         (w_key[g]),
            .o_handle      (w_handle[g]),
            .o_take_key    (w_tkey[g]),
            .o_take_handle (w_thandle[g])
        );
    end

    assign w_hit = w_hit_chain[DEPTH];

    // gather the removed word (at most one cell takes)
    always_comb begin
        w_sel_key    = '0;
        w_sel_handle = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_key    = w_sel_key | w_tkey[i];
            w_sel_handle = w_sel_handle | w_thandle[i];
        end
    end

    // result and fill level
    always_comb begin
        n_count      = r_count;
        n_status     = oqkr_pkg::ST_MISS;
        n_out_key    = '0;
        n_out_handle = '0;
        if (w_ctl.do_append) begin
            n_count  = r_count + CNT_W'(1);
            n_status = oqkr_pkg::ST_OK;
        end else if (w_accept && (i_req_type == oqkr_pkg::OP_APPEND)) begin
            n_status = oqkr_pkg::ST_FULL;
        end else if (w_hit) begin
            n_count      = r_count - CNT_W'(1);
            n_status     = oqkr_pkg::ST_OK;
            n_out_key    = w_sel_key;
            n_out_handle = w_sel_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_out_key    <= n_out_key;
            r_out_handle <= n_out_handle;
            r_out_count  <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_key    = r_out_key;
    assign o_out_handle = r_out_handle;
    assign o_count      = r_out_count;

`ifndef SYNTH
    // fill level stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond capacity");

    // at most one slot is taken per request
    a_single_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take))
        else $error("more than one slot removed");

    // a removal that misses leaves the fill level alone
    a_miss_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == oqkr_pkg::OP_REMOVE) && !w_hit)
        |=> (r_count == $past(r_count)))
        else $error("count changed on a missed removal");

    // a taken slot must lie inside the occupied region
    a_take_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (r_count != '0))
        else $error("hit on an empty queue");
`endif

endmodule

@@ tb/oqkr_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oqkr_result_checker
// Watches both channels of the ordered queue, keeps its own copy of the
// queue contents, predicts one result word per request word and compares
// every result word field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module oqkr_result_checker #(
    parameter int DEPTH        = 16,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 32,
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [KEY_WIDTH-1:0]    i_msg_key,
    input  logic [HANDLE_WIDTH-1:0] i_msg_handle,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [1:0]              i_status,
    input  logic [KEY_WIDTH-1:0]    i_out_key,
    input  logic [HANDLE_WIDTH-1:0] i_out_handle,
    input  logic [CNT_W-1:0]        i_count,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct packed {
        logic [1:0]              status;
        logic [KEY_WIDTH-1:0]    key;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [CNT_W-1:0]        count;
    } t_queue_result;

    // shadow copy of the queue, oldest entry at place 0
    logic [KEY_WIDTH-1:0]    shadow_key    [DEPTH];
    logic [HANDLE_WIDTH-1:0] shadow_handle [DEPTH];
    int                      shadow_fill;

    t_queue_result expected_results [$];

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        shadow_fill = 0;
    end

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_errors++;
    endtask

    // apply one request to the shadow queue and give the result it yields
    function automatic t_queue_result apply_request(
        input logic [1:0]              op,
        input logic [KEY_WIDTH-1:0]    key,
        input logic [HANDLE_WIDTH-1:0] handle
    );
        t_queue_result res;
        int            hit;
        int            i;
        res.status = oqkr_pkg::ST_MISS;
        res.key    = '0;
        res.handle = '0;
        hit        = -1;
        case (op)
            oqkr_pkg::OP_APPEND: begin
                if (shadow_fill < DEPTH) begin
                    shadow_key[shadow_fill]    = key;
                    shadow_handle[shadow_fill] = handle;
                    shadow_fill++;
                    res.status = oqkr_pkg::ST_OK;
                end else begin
                    res.status = oqkr_pkg::ST_FULL;
                end
            end
            oqkr_pkg::OP_REMOVE: begin
                // oldest match wins
                for (i = 0; i < shadow_fill; i++) begin
                    if (hit < 0 && shadow_key[i] == key) begin
                        hit = i;
                    end
                end
            end
            oqkr_pkg::OP_POP: begin
                if (shadow_fill > 0) begin
                    hit = 0;
                end
            end
            default: ;
        endcase
        // take the entry out and close the gap behind it
        if (hit >= 0) begin
            res.status = oqkr_pkg::ST_OK;
            res.key    = shadow_key[hit];
            res.handle = shadow_handle[hit];
            for (i = hit + 1; i < shadow_fill; i++) begin
                shadow_key[i-1]    = shadow_key[i];
                shadow_handle[i-1] = shadow_handle[i];
            end
            shadow_fill--;
        end
        res.count = CNT_W'(shadow_fill);
        return res;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_queue_result want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    if (i_out_key !== want.key)
                        report_mismatch($sformatf("out_key got %h want %h",
                                                  i_out_key, want.key));
                    if (i_out_handle !== want.handle)
                        report_mismatch($sformatf("out_handle got %h want %h",
                                                  i_out_handle, want.handle));
                    if (i_count !== want.count)
                        report_mismatch($sformatf("count got %0d want %0d",
                                                  i_count, want.count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(
                    apply_request(i_req_type, i_msg_key, i_msg_handle));
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ordered queue with keyed removal. A directed
// opening covers empty, full, duplicate-key and unused-code cases; a random
// run then swings the queue between filling and draining with keys drawn
// from small pools so that removals hit. The checker does the comparing.
// ---------------------------------------------------------------------------
module tb;

    localparam int DEPTH        = 16;
    localparam int KEY_WIDTH    = 16;
    localparam int HANDLE_WIDTH = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS   = 1250;
    localparam int HOLD_OFF_AT    = 400;
    localparam int HOLD_OFF_SPAN  = 250;
    localparam int DRAIN_AT       = 700;
    localparam int CYCLE_LIMIT    = 200000;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [1:0]              req_type   = oqkr_pkg::OP_APPEND;
    logic [KEY_WIDTH-1:0]    msg_key    = '0;
    logic [HANDLE_WIDTH-1:0] msg_handle = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic [1:0]              status;
    logic [KEY_WIDTH-1:0]    out_key;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [CNT_W-1:0]        count;

    int errors;
    int pending;
    int words_sent = 0;
    int cycles     = 0;

    always #2 clk = ~clk;

    ordered_queue_keyed_remove #(
        .DEPTH        (DEPTH),
        .KEY_WIDTH    (KEY_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_msg_key    (msg_key),
        .i_msg_handle (msg_handle),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_out_key    (out_key),
        .o_out_handle (out_handle),
        .o_count      (count)
    );

    oqkr_result_checker #(
        .DEPTH        (DEPTH),
        .KEY_WIDTH    (KEY_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_msg_key    (msg_key),
        .i_msg_handle (msg_handle),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_status     (status),
        .i_out_key    (out_key),
        .i_out_handle (out_handle),
        .i_count      (count),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL ordered_queue_keyed_remove");
            $finish;
        end
    end

    // offer one request word and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [KEY_WIDTH-1:0] key,
                             input logic [HANDLE_WIDTH-1:0] handle);
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= op;
        msg_key    <= key;
        msg_handle <= handle;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic idle_for(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop offering until every result word has come back
    task automatic wait_drained();
        idle_for(1);
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: stall patterns of varying density, plus one long hold-off
    initial begin : receiver
        int  mode;
        int  span;
        bit  held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever begin
            if (!held_off && words_sent >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_SPAN - 1) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // sender
    initial begin : sender
        int                   i;
        int                   burst;
        int                   roll;
        int                   phase_left;
        int                   random_sent;
        bit                   fill_phase;
        bit                   drained;
        logic [1:0]           op;
        logic [KEY_WIDTH-1:0] key;
        logic [KEY_WIDTH-1:0] key_base;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // empty queue: pop, remove and the unused code all miss
        send_word(oqkr_pkg::OP_POP,    16'h1234, 32'hDEAD_BEEF);
        send_word(oqkr_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000);
        send_word(OP_UNUSED,           16'hFFFF, 32'hFFFF_FFFF);
        // field extremes and a duplicated key
        send_word(oqkr_pkg::OP_APPEND, 16'h0000, 32'h0000_0000);
        send_word(oqkr_pkg::OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(oqkr_pkg::OP_APPEND, 16'h0000, 32'h5A5A_A5A5);
        // only the older of the two zero keys goes
        send_word(oqkr_pkg::OP_REMOVE, 16'h0000, 32'hFFFF_FFFF);
        send_word(oqkr_pkg::OP_REMOVE, 16'h1234, 32'h0000_0000);
        send_word(OP_UNUSED,           16'h0000, 32'h0000_0000);
        // fill up, then one append too many
        for (i = 0; i < DEPTH - 2; i++) begin
            send_word(oqkr_pkg::OP_APPEND, KEY_WIDTH'(16'h0100 + i), $urandom);
        end
        send_word(oqkr_pkg::OP_APPEND, 16'hAAAA, 32'h5555_5555);
        send_word(oqkr_pkg::OP_REMOVE, 16'h0105, 32'h0000_0000);
        send_word(oqkr_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        wait_drained();

        // random part: alternate between filling and draining phases
        random_sent = 0;
        fill_phase  = 1'b1;
        phase_left  = $urandom_range(20, 80);
        key_base    = KEY_WIDTH'($urandom);
        drained     = 1'b0;
        while (random_sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (phase_left == 0) begin
                    fill_phase = !fill_phase;
                    phase_left = $urandom_range(20, 80);
                    key_base   = KEY_WIDTH'($urandom);
                end
                phase_left--;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    op = OP_UNUSED;
                else if (roll < (fill_phase ? 64 : 30))
                    op = oqkr_pkg::OP_APPEND;
                else if (roll < (fill_phase ? 88 : 68))
                    op = oqkr_pkg::OP_REMOVE;
                else
                    op = oqkr_pkg::OP_POP;
                // mostly a small pool of keys so removals find matches
                if ($urandom_range(0, 3) == 0)
                    key = KEY_WIDTH'($urandom);
                else
                    key = key_base ^ KEY_WIDTH'($urandom_range(0, 7));
                send_word(op, key, HANDLE_WIDTH'($urandom));
                random_sent++;
                if (!drained && random_sent == DRAIN_AT) begin
                    wait_drained();
                    drained = 1'b1;
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_for($urandom_range(1, 10));
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (errors == 0) begin
            $display("PASS ordered_queue_keyed_remove");
        end else begin
            $display("FAIL ordered_queue_keyed_remove");
        end
        $finish;
    end

endmodule
